### hdl/ttb_pkg.sv
// Shared widths, controller states and command/status structs for the
// triangle tangent/binormal block. No dependencies.
`timescale 1ns / 1ps
package ttb_pkg;
  localparam int PosW  = 32;  // Q16.16 position
  localparam int TexW  = 24;  // Q8.16 texture coordinate
  localparam int EdgeW = 33;  // position difference
  localparam int DltW  = 25;  // texture difference
  localparam int MulW  = 34;  // shared multiplier operand
  localparam int ProdW = 2 * MulW;
  localparam int VecW  = 59;  // unnormalized tangent/binormal component
  localparam int MagW  = 58;  // its magnitude
  localparam int NrmW  = 30;  // magnitude after normalizing shift
  localparam int SumW  = 62;  // sum of three squares
  localparam int RootW = 63;  // square root iteration width
  localparam int LenW  = 32;  // vector length
  localparam int DivW  = 47;  // divider remainder
  localparam int QW    = 17;  // quotient
  localparam int OutW  = 16;  // Q1.14 result
  localparam int FracW = 14;
  localparam int SqrtSteps = RootW / 2 + 1;
  localparam int DivSteps  = QW - 1;
  localparam logic [QW-1:0] QOne = QW'(16384);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_NLOAD, ST_NCHK, ST_NSHIFT, ST_NSQ, ST_SQI,
    ST_SQRT, ST_DIVI, ST_DIV, ST_DIVS, ST_NEXTV, ST_DONE
  } state_t;

  typedef struct packed {
    logic       store_first;
    logic       store_second;
    logic       capture;
    logic       mul_en;
    logic       mul_second;
    logic       mul_sq;
    logic [2:0] idx;
    logic       acc_load;
    logic       res_store;
    logic       norm_load;
    logic       vec_sel;
    logic       vec_clear;
    logic       shift_en;
    logic       sum_load;
    logic       sum_add;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       out_load;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic shift_done;
  } sts_t;
endpackage

### hdl/ttb_if.sv
// Valid/ready channels for vertex input and tangent-space results.
// Depends on ttb_pkg for field widths.
`timescale 1ns / 1ps
interface ttb_vtx_if;
  import ttb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  logic signed [TexW-1:0] tex_u;
  logic signed [TexW-1:0] tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_res_if;
  import ttb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] tangent_x;
  logic signed [OutW-1:0] tangent_y;
  logic signed [OutW-1:0] tangent_z;
  logic signed [OutW-1:0] binormal_x;
  logic signed [OutW-1:0] binormal_y;
  logic signed [OutW-1:0] binormal_z;
  logic                   degenerate;
  modport source (output valid, tangent_x, tangent_y, tangent_z, binormal_x,
                  binormal_y, binormal_z, degenerate, input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, binormal_x,
                binormal_y, binormal_z, degenerate, output ready);
endinterface

### hdl/ttb_ctrl.sv
// Sequencer for vertex slots, products, normalization, square root and divide.
// Depends on ttb_pkg.
`timescale 1ns / 1ps
module ttb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          vtx_valid,
  output logic          vtx_ready,
  output logic          res_valid,
  input  logic          res_ready,
  output ttb_pkg::cmd_t cmd,
  input  ttb_pkg::sts_t sts
);
  import ttb_pkg::*;

  state_t     state, state_next;
  logic [1:0] slot;
  logic [2:0] r;
  logic [4:0] cnt;
  logic [1:0] comp;
  logic       vec;
  logic       vtx_acc;

  assign vtx_ready = (state == ST_IDLE) && !((slot == 2'd2) && res_valid);
  assign vtx_acc   = vtx_valid && vtx_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (vtx_acc && slot == 2'd2) state_next = ST_PROD;
      ST_PROD: begin
        if (cnt == 5'd2 && r == 3'd6) state_next = sts.det_zero ? ST_DONE : ST_NLOAD;
      end
      ST_NLOAD:  state_next = ST_NCHK;
      ST_NCHK:   state_next = sts.vec_zero ? ST_NEXTV : ST_NSHIFT;
      ST_NSHIFT: if (sts.shift_done) state_next = ST_NSQ;
      ST_NSQ:    if (cnt == 5'd3) state_next = ST_SQI;
      ST_SQI:    state_next = ST_SQRT;
      ST_SQRT:   if (cnt == 5'(SqrtSteps - 1)) state_next = ST_DIVI;
      ST_DIVI:   state_next = ST_DIV;
      ST_DIV:    if (cnt == 5'(DivSteps - 1)) state_next = ST_DIVS;
      ST_DIVS:   state_next = (comp == 2'd2) ? ST_NEXTV : ST_DIVI;
      ST_NEXTV:  state_next = vec ? ST_DONE : ST_NLOAD;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= 2'd0;
      r         <= 3'd0;
      cnt       <= 5'd0;
      comp      <= 2'd0;
      vec       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PROD) begin
        if (cnt == 5'd2) begin
          cnt <= 5'd0;
          r   <= r + 3'd1;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end else if (state_next != state) begin
        cnt <= 5'd0;
      end else begin
        cnt <= cnt + 5'd1;
      end
      if (state == ST_IDLE) begin
        r   <= 3'd0;
        vec <= 1'b0;
        if (vtx_acc) begin
          slot <= (slot == 2'd1) ? 2'd2 : (slot == 2'd2) ? 2'd0 : 2'd1;
        end
      end
      if (state == ST_NLOAD) comp <= 2'd0;
      if (state == ST_DIVS) comp <= comp + 2'd1;
      if (state == ST_NEXTV) vec <= 1'b1;
      if (state == ST_DONE) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.vec_sel = vec;
    cmd.comp    = comp;
    unique case (state)
      ST_IDLE: begin
        cmd.store_first  = vtx_acc && (slot == 2'd0 || slot == 2'd3);
        cmd.store_second = vtx_acc && (slot == 2'd1);
        cmd.capture      = vtx_acc && (slot == 2'd2);
      end
      ST_PROD: begin
        cmd.idx = r;
        case (cnt)
          5'd0:    cmd.mul_en = 1'b1;
          5'd1: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_second = 1'b1;
            cmd.acc_load   = 1'b1;
          end
          default: cmd.res_store = 1'b1;
        endcase
      end
      ST_NLOAD: cmd.norm_load = 1'b1;
      ST_NCHK:  cmd.vec_clear = sts.vec_zero;
      ST_NSHIFT: cmd.shift_en = !sts.shift_done;
      ST_NSQ: begin
        cmd.comp   = cnt[1:0];
        cmd.mul_sq = 1'b1;
        cmd.mul_en = (cnt != 5'd3);
        cmd.sum_load = (cnt == 5'd1);
        cmd.sum_add  = (cnt == 5'd2) || (cnt == 5'd3);
      end
      ST_SQI:   cmd.sqrt_init = 1'b1;
      ST_SQRT:  cmd.sqrt_step = 1'b1;
      ST_DIVI:  cmd.div_init = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_DIVS:  cmd.div_store = 1'b1;
      ST_NEXTV: ;
      ST_DONE:  cmd.out_load = 1'b1;
      default:  ;
    endcase
  end
endmodule

### hdl/ttb_dp.sv
// Datapath: vertex store, shared multiplier, normalizing shifter,
// bit-pair square root and restoring divider. Depends on ttb_pkg.
`timescale 1ns / 1ps
module ttb_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  ttb_pkg::cmd_t                   cmd,
  output ttb_pkg::sts_t                   sts,
  input  logic signed [ttb_pkg::PosW-1:0] pos_x,
  input  logic signed [ttb_pkg::PosW-1:0] pos_y,
  input  logic signed [ttb_pkg::PosW-1:0] pos_z,
  input  logic signed [ttb_pkg::TexW-1:0] tex_u,
  input  logic signed [ttb_pkg::TexW-1:0] tex_v,
  output logic signed [ttb_pkg::OutW-1:0] tangent_x,
  output logic signed [ttb_pkg::OutW-1:0] tangent_y,
  output logic signed [ttb_pkg::OutW-1:0] tangent_z,
  output logic signed [ttb_pkg::OutW-1:0] binormal_x,
  output logic signed [ttb_pkg::OutW-1:0] binormal_y,
  output logic signed [ttb_pkg::OutW-1:0] binormal_z,
  output logic                            degenerate
);
  import ttb_pkg::*;

  logic signed [PosW-1:0]  p_in [3];
  logic signed [PosW-1:0]  p1 [3];
  logic signed [PosW-1:0]  p2 [3];
  logic signed [TexW-1:0]  t1 [2];
  logic signed [TexW-1:0]  t2 [2];
  logic signed [EdgeW-1:0] e1 [3];
  logic signed [EdgeW-1:0] e2 [3];
  logic signed [DltW-1:0]  du1, dv1, du2, dv2;
  logic signed [MulW-1:0]  opa, opb;
  logic signed [ProdW-1:0] prod;
  logic signed [VecW-1:0]  acc, diff, vstore;
  logic signed [VecW-1:0]  vecs [6];
  logic                    det_zero, det_neg, degen;
  logic [MagW-1:0]         mag [3];
  logic [MagW-1:0]         mload [3];
  logic                    sgn [3];
  logic [MagW-1:0]         m, mmax;
  logic [SumW-1:0]         sum;
  logic [RootW-1:0]        sx, sr, sbit, strial;
  logic [DivW-1:0]         rem, den;
  logic [QW-1:0]           q, qc;
  logic signed [OutW-1:0]  res_q [6];
  logic [2:0]              ridx, pidx;
  logic [1:0]              ei;

  assign p_in[0] = pos_x;
  assign p_in[1] = pos_y;
  assign p_in[2] = pos_z;

  // product selection: idx 0 is the determinant, 1..3 tangent, 4..6 binormal
  always_comb begin
    pidx = (cmd.idx <= 3'd3) ? cmd.idx - 3'd1 : cmd.idx - 3'd4;
    ei   = pidx[1:0];
    opa  = '0;
    opb  = '0;
    if (cmd.mul_sq) begin
      opa = MulW'(signed'({1'b0, mag[cmd.comp][NrmW-1:0]}));
      opb = opa;
    end else begin
      case (cmd.idx)
        3'd0: begin
          opa = MulW'(cmd.mul_second ? du2 : du1);
          opb = MulW'(cmd.mul_second ? dv1 : dv2);
        end
        3'd1, 3'd2, 3'd3: begin
          opa = MulW'(cmd.mul_second ? dv1 : dv2);
          opb = MulW'(cmd.mul_second ? e2[ei] : e1[ei]);
        end
        default: begin
          opa = MulW'(cmd.mul_second ? du2 : du1);
          opb = MulW'(cmd.mul_second ? e1[ei] : e2[ei]);
        end
      endcase
    end
  end

  assign diff   = acc - signed'(prod[VecW-1:0]);
  assign vstore = det_neg ? -diff : diff;
  assign ridx   = cmd.vec_sel ? 3'd3 + {1'b0, cmd.comp} : {1'b0, cmd.comp};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [VecW-1:0] v;
      logic signed [VecW-1:0] vn;
      v  = vecs[cmd.vec_sel ? 3 + i : i];
      vn = -v;
      mload[i] = v[VecW-1] ? vn[MagW-1:0] : v[MagW-1:0];
    end
    mmax = mload[0];
    if (mload[1] > mmax) mmax = mload[1];
    if (mload[2] > mmax) mmax = mload[2];
  end

  assign sts.det_zero   = det_zero;
  assign sts.vec_zero   = (m == '0);
  assign sts.shift_done = (m[MagW-1:NrmW] == '0) && m[NrmW-1];

  assign strial = sr + sbit;
  assign qc     = (q > QOne) ? QOne : q;

  always_ff @(posedge clk) begin
    if (cmd.store_first) begin
      for (int i = 0; i < 3; i++) p1[i] <= p_in[i];
      t1[0] <= tex_u;
      t1[1] <= tex_v;
    end
    if (cmd.store_second) begin
      for (int i = 0; i < 3; i++) p2[i] <= p_in[i];
      t2[0] <= tex_u;
      t2[1] <= tex_v;
    end
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EdgeW'(p2[i]) - EdgeW'(p1[i]);
        e2[i] <= EdgeW'(p_in[i]) - EdgeW'(p1[i]);
      end
      du1 <= DltW'(t2[0]) - DltW'(t1[0]);
      dv1 <= DltW'(t2[1]) - DltW'(t1[1]);
      du2 <= DltW'(tex_u) - DltW'(t1[0]);
      dv2 <= DltW'(tex_v) - DltW'(t1[1]);
    end
    if (cmd.mul_en) prod <= opa * opb;
    if (cmd.acc_load) acc <= signed'(prod[VecW-1:0]);
    if (cmd.res_store) begin
      if (cmd.idx == 3'd0) begin
        det_zero <= (diff == '0);
        det_neg  <= diff[VecW-1];
      end else begin
        // tangent lands in 0..2, binormal in 3..5
        vecs[cmd.idx - 3'd1] <= vstore;
      end
    end
    if (cmd.norm_load) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= mload[i];
        sgn[i] <= vecs[cmd.vec_sel ? 3 + i : i][VecW-1];
      end
      m <= mmax;
    end
    if (cmd.vec_clear) begin
      for (int i = 0; i < 3; i++) res_q[cmd.vec_sel ? 3 + i : i] <= '0;
    end
    // right shifts truncate, exactly as a single wide shift would
    if (cmd.shift_en) begin
      if (m[MagW-1:NrmW] != '0) begin
        for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        m <= m >> 1;
      end else begin
        for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        m <= m << 1;
      end
    end
    if (cmd.sum_load) sum <= prod[SumW-1:0];
    if (cmd.sum_add) sum <= sum + prod[SumW-1:0];
    if (cmd.sqrt_init) begin
      sx   <= RootW'(sum);
      sr   <= '0;
      sbit <= RootW'(1) << (RootW - 1);
    end
    if (cmd.sqrt_step) begin
      if (sx >= strial) begin
        sx <= sx - strial;
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.div_init) begin
      rem <= DivW'({mag[cmd.comp][NrmW-1:0], FracW'(0)}) + DivW'(sr[LenW-1:1]);
      den <= DivW'(sr[LenW-1:0]) << (QW - 2);
      q   <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= den) begin
        rem <= rem - den;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        q <= {q[QW-2:0], 1'b0};
      end
      den <= den >> 1;
    end
    if (cmd.div_store) begin
      res_q[ridx] <= sgn[cmd.comp] ? -signed'(qc[OutW-1:0]) : signed'(qc[OutW-1:0]);
    end
    if (cmd.out_load) begin
      tangent_x  <= det_zero ? '0 : res_q[0];
      tangent_y  <= det_zero ? '0 : res_q[1];
      tangent_z  <= det_zero ? '0 : res_q[2];
      binormal_x <= det_zero ? '0 : res_q[3];
      binormal_y <= det_zero ? '0 : res_q[4];
      binormal_z <= det_zero ? '0 : res_q[5];
      degenerate <= det_zero | degen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degen <= 1'b0;
    end else if (cmd.capture) begin
      degen <= 1'b0;
    end else if (cmd.vec_clear) begin
      degen <= 1'b1;
    end
  end
endmodule

### hdl/triangle_tangent_binormal.sv
// Top level of the per-triangle tangent/binormal unit.
// Depends on ttb_pkg, ttb_if, ttb_ctrl and ttb_dp.
`timescale 1ns / 1ps
// Vertices stream in one transaction at a time; the first two of a triangle
// are stored, and the third starts the computation, which yields one
// result transaction per triangle. A triangle runs its products on one
// shared 34x34 multiplier, then for each of the two vectors the one-bit
// normalizing shifts, the squares, the bit-pair square root and three
// divides. A zero UV determinant ends after the products and returns zero
// vectors with degenerate set.
module triangle_tangent_binormal (
  input logic    clk,
  input logic    rst,
  ttb_vtx_if.sink   vtx,
  ttb_res_if.source res
);
  import ttb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ttb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx.valid),
    .vtx_ready (vtx.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ttb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .pos_x      (vtx.pos_x),
    .pos_y      (vtx.pos_y),
    .pos_z      (vtx.pos_z),
    .tex_u      (vtx.tex_u),
    .tex_v      (vtx.tex_v),
    .tangent_x  (res.tangent_x),
    .tangent_y  (res.tangent_y),
    .tangent_z  (res.tangent_z),
    .binormal_x (res.binormal_x),
    .binormal_y (res.binormal_y),
    .binormal_z (res.binormal_z),
    .degenerate (res.degenerate)
  );
endmodule

### bench/triangle_tangent_binormal_test.sv
// Self-checking bench for triangle_tangent_binormal: directed triangles, then
// random triangles checked against an in-bench tangent-space predictor.
// Depends on ttb_pkg, ttb_if and the RTL of the block.
`timescale 1ns / 1ps
module triangle_tangent_binormal_test;
  import ttb_pkg::*;

  typedef struct {
    logic [PosW-1:0] px, py, pz;
    logic [TexW-1:0] tu, tv;
  } vertex_t;

  typedef struct packed {
    logic [OutW-1:0] tx, ty, tz, bx, by, bz;
    logic            dg;
  } frame_t;

  typedef struct {
    vertex_t v;
    bit      typed;
    frame_t  e;
  } dir_row_t;

  localparam logic [PosW-1:0] P_ONE = 32'h0001_0000;
  localparam logic [TexW-1:0] T_ONE = 24'h01_0000;
  localparam logic [OutW-1:0] Q_ONE = 16'd16384;
  localparam int NDIR = 21;
  localparam int NRAND = 1602;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ttb_vtx_if vtx ();
  ttb_res_if res ();

  triangle_tangent_binormal u_dut (.clk(clk), .rst(rst), .vtx(vtx.sink), .res(res.source));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int              slot_cnt = 0;
  longint signed   p1[3], p2[3];
  longint signed   t1[2], t2[2];
  frame_t          frame_q[$];
  int              mismatches = 0;
  bit              no_idle = 1'b0;
  dir_row_t        dir_tab[NDIR];

  function automatic void unit_q14(input longint signed vin[3], output logic [OutW-1:0] o[3],
                                   output bit nonzero);
    longint unsigned mg[3];
    longint unsigned mx, tmp, sum, x, r, bitv, q;
    int b;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (vin[i] < 0) ? longint'(-vin[i]) : longint'(vin[i]);
      if (mg[i] > mx) mx = mg[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = '0;
      nonzero = 1'b0;
      return;
    end
    b = 0;
    tmp = mx;
    while (tmp != 0) begin
      b++;
      tmp >>= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (b > 30) mg[i] = mg[i] >> (b - 30);
      else mg[i] = mg[i] << (30 - b);
      sum += mg[i] * mg[i];
    end
    // bit-pair integer square root
    x = sum;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 14) + (r >> 1)) / r;
      if (q > 16384) q = 16384;
      o[i] = (vin[i] < 0) ? OutW'(-q) : OutW'(q);
    end
    nonzero = 1'b1;
  endfunction

  // advance the vertex slot; returns 1 when the vertex closes a triangle
  function automatic bit predict_frame(input vertex_t v, output frame_t f);
    longint signed p[3], t[2], e1[3], e2[3], tg[3], bn[3];
    longint signed du1, dv1, du2, dv2, det;
    logic [OutW-1:0] tq[3], bq[3];
    bit tn, bnz;
    p[0] = longint'($signed(v.px));
    p[1] = longint'($signed(v.py));
    p[2] = longint'($signed(v.pz));
    t[0] = longint'($signed(v.tu));
    t[1] = longint'($signed(v.tv));
    f = '{default: '0};
    if (slot_cnt == 1) begin
      p2 = p;
      t2 = t;
      slot_cnt = 2;
      return 1'b0;
    end
    if (slot_cnt != 2) begin
      p1 = p;
      t1 = t;
      slot_cnt = 1;
      return 1'b0;
    end
    slot_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = p2[i] - p1[i];
      e2[i] = p[i] - p1[i];
    end
    du1 = t2[0] - t1[0];
    dv1 = t2[1] - t1[1];
    du2 = t[0] - t1[0];
    dv2 = t[1] - t1[1];
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) begin
      f.dg = 1'b1;
      return 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      tg[i] = dv2 * e1[i] - dv1 * e2[i];
      bn[i] = du1 * e2[i] - du2 * e1[i];
      if (det < 0) begin
        tg[i] = -tg[i];
        bn[i] = -bn[i];
      end
    end
    unit_q14(tg, tq, tn);
    unit_q14(bn, bq, bnz);
    f.tx = tq[0]; f.ty = tq[1]; f.tz = tq[2];
    f.bx = bq[0]; f.by = bq[1]; f.bz = bq[2];
    f.dg = !(tn && bnz);
    return 1'b1;
  endfunction

  function automatic dir_row_t row(input logic [PosW-1:0] px, py, pz,
                                   input logic [TexW-1:0] tu, tv);
    dir_row_t d;
    d.v = '{px: px, py: py, pz: pz, tu: tu, tv: tv};
    d.typed = 1'b0;
    d.e = '{default: '0};
    return d;
  endfunction

  function automatic frame_t fr(input logic [OutW-1:0] tx, ty, tz, bx, by, bz,
                                input logic dg);
    fr = '{tx: tx, ty: ty, tz: tz, bx: bx, by: by, bz: bz, dg: dg};
  endfunction

  function automatic logic [PosW-1:0] rand_pos();
    return PosW'($signed($urandom) >>> $urandom_range(0, 31));
  endfunction

  function automatic logic [TexW-1:0] rand_tex();
    return TexW'($signed(TexW'($urandom)) >>> $urandom_range(0, 23));
  endfunction

  task automatic send_vertex(input vertex_t v, input bit typed, input frame_t e);
    frame_t f;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 21) begin
      vtx.valid <= 1'b0;
      @(negedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.pos_x <= v.px;
    vtx.pos_y <= v.py;
    vtx.pos_z <= v.pz;
    vtx.tex_u <= v.tu;
    vtx.tex_v <= v.tv;
    do @(posedge clk); while (!vtx.ready);
    if (predict_frame(v, f)) frame_q.push_back(typed ? e : f);
  endtask

  always @(negedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= no_idle || ($urandom_range(99) >= 21);
  end

  // result checker
  always @(posedge clk) begin
    frame_t w, g;
    if (!rst && res.valid && res.ready) begin
      g = fr(res.tangent_x, res.tangent_y, res.tangent_z, res.binormal_x,
             res.binormal_y, res.binormal_z, res.degenerate);
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", g);
      end else begin
        w = frame_q.pop_front();
        if (g !== w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", w, g);
        end
      end
    end
  end

  initial begin
    vertex_t v, base;
    int mode;
    vtx.valid = 1'b0;
    vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0;
    vtx.tex_u = '0; vtx.tex_v = '0;

    // all-zero triangle: zero determinant
    dir_tab[0] = row(0, 0, 0, 0, 0);
    dir_tab[1] = row(0, 0, 0, 0, 0);
    dir_tab[2] = row(0, 0, 0, 0, 0);
    dir_tab[2].typed = 1'b1;
    dir_tab[2].e = fr(0, 0, 0, 0, 0, 0, 1'b1);
    // unit axes, positive determinant
    dir_tab[3] = row(0, 0, 0, 0, 0);
    dir_tab[4] = row(P_ONE, 0, 0, T_ONE, 0);
    dir_tab[5] = row(0, P_ONE, 0, 0, T_ONE);
    dir_tab[5].typed = 1'b1;
    dir_tab[5].e = fr(Q_ONE, 0, 0, 0, Q_ONE, 0, 1'b0);
    // position extremes
    dir_tab[6] = row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h80_0000, 24'h7F_FFFF);
    dir_tab[7] = row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h7F_FFFF, 24'h80_0000);
    dir_tab[8] = row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'h7F_FFFF, 24'h7F_FFFF);
    // coincident positions: both vectors zero length
    dir_tab[9] = row(P_ONE, P_ONE, P_ONE, 0, 0);
    dir_tab[10] = row(P_ONE, P_ONE, P_ONE, T_ONE, 0);
    dir_tab[11] = row(P_ONE, P_ONE, P_ONE, 0, T_ONE);
    dir_tab[11].typed = 1'b1;
    dir_tab[11].e = fr(0, 0, 0, 0, 0, 0, 1'b1);
    // only the tangent is zero length
    dir_tab[12] = row(0, 0, 0, 0, 0);
    dir_tab[13] = row(0, 0, 0, T_ONE, 0);
    dir_tab[14] = row(0, P_ONE, 0, 0, T_ONE);
    dir_tab[14].typed = 1'b1;
    dir_tab[14].e = fr(0, 0, 0, 0, Q_ONE, 0, 1'b1);
    // negative determinant flips both vectors
    dir_tab[15] = row(0, 0, 0, 0, 0);
    dir_tab[16] = row(P_ONE, 0, 0, 0, T_ONE);
    dir_tab[17] = row(0, P_ONE, 0, T_ONE, 0);
    dir_tab[17].typed = 1'b1;
    dir_tab[17].e = fr(0, Q_ONE, 0, Q_ONE, 0, 0, 1'b0);
    // texture extremes, mixed positions
    dir_tab[18] = row(32'hFFFF_FFFF, 1, 32'h8000_0000, 24'h80_0000, 24'h80_0000);
    dir_tab[19] = row(32'h0012_3456, 32'hFFFE_0000, 32'h7FFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
    dir_tab[20] = row(1, 32'h8000_0000, 0, 24'h80_0000, 24'h7F_FFFF);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_vertex(dir_tab[i].v, dir_tab[i].typed, dir_tab[i].e);

    base = '{default: '0};
    for (int n = 0; n < NRAND; n++) begin
      no_idle = (n >= 600 && n < 900);
      v = '{px: rand_pos(), py: rand_pos(), pz: rand_pos(), tu: rand_tex(), tv: rand_tex()};
      if (slot_cnt == 0) begin
        base = v;
      end else begin
        mode = $urandom_range(0, 19);
        // steer a few triangles into degenerate corners
        if (mode == 0) begin
          v.tu = base.tu;
          v.tv = base.tv;
        end else if (mode == 1) begin
          v.px = base.px; v.py = base.py; v.pz = base.pz;
        end else if (mode == 2) begin
          v.px = base.px + PosW'($signed(8'($urandom)));
          v.tu = base.tu + TexW'($signed(6'($urandom)));
        end
      end
      send_vertex(v, 1'b0, '{default: '0});
    end
    @(negedge clk);
    vtx.valid <= 1'b0;

    while (frame_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

### sim.f
hdl/ttb_pkg.sv
hdl/ttb_if.sv
hdl/ttb_ctrl.sv
hdl/ttb_dp.sv
hdl/triangle_tangent_binormal.sv
bench/triangle_tangent_binormal_test.sv
